>>> hw/rtl/chained_hash_table_macros.svh
// Assertion macros for the hash table RTL.
`ifndef CHAINED_HASH_TABLE_MACROS_SVH
`define CHAINED_HASH_TABLE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while reset is high.
`define CHT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while reset is high.
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/cht_pkg.sv
// Types and constants shared by the hash table modules.
package cht_pkg;

   localparam int unsigned KEY_BITS    = 31;
   localparam int unsigned OP_BITS     = 2;
   localparam int unsigned STATUS_BITS = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

endpackage

>>> hw/rtl/cht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cht_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/cht_mod.sv
// Bucket index unit: key modulo the bucket count.
module cht_mod
   import cht_pkg::*;
#(
   parameter int unsigned BUCKETS = 256,
   localparam int unsigned BB = $clog2(BUCKETS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_BITS-1:0] key,
   output logic                done,
   output logic [BB-1:0]       bucket
);

   localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

   logic          done_ff;
   logic [BB-1:0] rem_ff;

   generate
      if (POW2) begin : g_mask
         // The remainder is just the low key bits.
         always_ff @(posedge clock) begin
            if (start) begin
               rem_ff <= key[BB-1:0];
            end
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end
      end else begin : g_recip
         // With SHIFT = KEY_BITS + BB and MAGIC = 2**SHIFT / BUCKETS rounded up, the
         // product bits above SHIFT are the exact quotient for every key. The product is
         // registered, then key minus quotient times BUCKETS is formed and registered.
         localparam int unsigned SHIFT = KEY_BITS + BB;
         localparam int unsigned MW    = 32;
         localparam int unsigned PW    = KEY_BITS + MW;
         localparam logic [63:0] MAGIC_FULL =
            ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
         localparam logic [MW-1:0]       MAGIC   = MAGIC_FULL[MW-1:0];
         localparam logic [KEY_BITS-1:0] DIVISOR = KEY_BITS'(BUCKETS);

         logic                mul_ff;
         logic                sub_ff;
         logic [KEY_BITS-1:0] key_ff;
         logic [PW-1:0]       prod_ff;
         logic [KEY_BITS-1:0] quot;
         logic [KEY_BITS-1:0] diff;

         assign quot = KEY_BITS'(prod_ff >> SHIFT);
         assign diff = key_ff - quot * DIVISOR;

         always_ff @(posedge clock) begin
            if (start) begin
               key_ff <= key;
            end
            if (mul_ff) begin
               prod_ff <= {{MW{1'b0}}, key_ff} * {{KEY_BITS{1'b0}}, MAGIC};
            end
            if (sub_ff) begin
               rem_ff <= diff[BB-1:0];
            end
            if (reset) begin
               mul_ff  <= 1'b0;
               sub_ff  <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               mul_ff  <= start;
               sub_ff  <= mul_ff;
               done_ff <= sub_ff;
            end
         end
      end
   endgenerate

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

>>> hw/rtl/chained_hash_table.sv
// Top level of the separate-chaining hash table: sequencer, bucket and node memories.
`include "chained_hash_table_macros.svh"

// Hash table with separate chaining over a fixed pool of NODES nodes. A request
// transfer carries an operation in req_tuser (insert, lookup, clear all) and a key
// and handle in req_tdata; every request yields exactly one response transfer with
// a status in rsp_tuser and the found handle in rsp_tdata. The bucket is the key
// modulo BUCKETS. Inserts take the next free node, store key and handle, and link
// the node in at the head of its bucket without a duplicate check; when the pool is
// full the insert is dropped and reported. Lookups walk the chain from the head and
// return the newest matching node. The block handles one request at a time and
// holds req_tready low until the response has been taken. The bucket index is the
// low key bits when BUCKETS is a power of two; otherwise the remainder unit forms it
// by a reciprocal multiply followed by a multiply-subtract, each registered. After
// that, an insert reads the bucket memory and then writes the node and the new
// head before it responds; a lookup reads one node per chain node visited, since
// each node read feeds the address of the next. A clear sweeps the bucket memory one
// entry per cycle. The same sweep runs after reset, with req_tready low until it ends.
module chained_hash_table
   import cht_pkg::*;
#(
   parameter int unsigned BUCKETS     = 256,
   parameter int unsigned NODES       = 1024,
   parameter int unsigned HANDLE_BITS = 16,
   localparam int unsigned REQ_DATA_W = ((KEY_BITS + HANDLE_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_DATA_W = ((HANDLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // key (31 bits), then handle, zero pad
   input  logic [OP_BITS-1:0]     req_tuser,   // op
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // found_handle, zero pad
   output logic [STATUS_BITS-1:0] rsp_tuser    // status
);

   localparam int unsigned BB     = $clog2(BUCKETS);
   localparam int unsigned NB     = $clog2(NODES);
   localparam int unsigned NU_W   = $clog2(NODES + 1);
   // A link is a valid bit above a node index.
   localparam int unsigned LINK_W = NB + 1;
   // Node word layout from the top: key, handle, next link.
   localparam int unsigned NODE_W = KEY_BITS + HANDLE_BITS + LINK_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_HEAD,
      S_WALK,
      S_RESP
   } state_type;

   state_type              state_ff, state_in;
   logic [BB-1:0]          clr_cnt_ff, clr_cnt_in;
   logic                   clr_rsp_ff, clr_rsp_in;
   logic [NU_W-1:0]        nodes_used_ff, nodes_used_in;
   op_type                 op_ff, op_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   status_type             status_ff, status_in;
   logic [HANDLE_BITS-1:0] found_ff, found_in;

   logic                   pool_full;
   logic [NB-1:0]          new_idx;
   op_type                 req_op;

   // Remainder unit.
   logic                   mod_start;
   logic                   mod_done;
   logic [BB-1:0]          mod_bucket;

   // Bucket memory ports.
   logic                   bkt_wr_en;
   logic [BB-1:0]          bkt_wr_addr;
   logic [LINK_W-1:0]      bkt_wr_data;
   logic                   bkt_rd_en;
   logic [LINK_W-1:0]      bkt_rd_data;

   // Node memory ports.
   logic                   node_wr_en;
   logic [NODE_W-1:0]      node_wr_data;
   logic                   node_rd_en;
   logic [NB-1:0]          node_rd_addr;
   logic [NODE_W-1:0]      node_rd_data;

   logic [KEY_BITS-1:0]    node_key;
   logic [HANDLE_BITS-1:0] node_handle;
   logic [LINK_W-1:0]      node_next;

   assign pool_full   = (nodes_used_ff == NU_W'(NODES));
   assign new_idx     = nodes_used_ff[NB-1:0];
   assign req_op      = op_type'(req_tuser);
   assign node_next   = node_rd_data[LINK_W-1:0];
   assign node_handle = node_rd_data[LINK_W +: HANDLE_BITS];
   assign node_key    = node_rd_data[LINK_W + HANDLE_BITS +: KEY_BITS];

   cht_mod #(
      .BUCKETS (BUCKETS)
   ) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .key    (req_tdata[KEY_BITS-1:0]),
      .done   (mod_done),
      .bucket (mod_bucket)
   );

   cht_ram #(
      .WIDTH (LINK_W),
      .DEPTH (BUCKETS)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_wr_en),
      .wr_addr (bkt_wr_addr),
      .wr_data (bkt_wr_data),
      .rd_en   (bkt_rd_en),
      .rd_addr (mod_bucket),
      .rd_data (bkt_rd_data)
   );

   cht_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (new_idx),
      .wr_data (node_wr_data),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_data)
   );

   // The new node links to whatever the bucket head held, empty or not.
   assign node_wr_data = {key_ff, handle_ff, bkt_rd_data};

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      nodes_used_in = nodes_used_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      mod_start     = 1'b0;
      bkt_wr_en     = 1'b0;
      bkt_wr_addr   = mod_bucket;
      bkt_wr_data   = '0;
      bkt_rd_en     = 1'b0;
      node_wr_en    = 1'b0;
      node_rd_en    = 1'b0;
      node_rd_addr  = bkt_rd_data[NB-1:0];

      case (state_ff)
         S_CLEAR: begin
            // Empty one bucket per cycle.
            bkt_wr_en   = 1'b1;
            bkt_wr_addr = clr_cnt_ff;
            if (clr_cnt_ff == BB'(BUCKETS - 1)) begin
               clr_cnt_in = '0;
               if (clr_rsp_ff) begin
                  status_in = ST_OK;
                  found_in  = '0;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_op;
               key_in    = req_tdata[KEY_BITS-1:0];
               handle_in = req_tdata[KEY_BITS +: HANDLE_BITS];
               found_in  = '0;
               case (req_op)
                  OP_INSERT: begin
                     if (pool_full) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        mod_start = 1'b1;
                        state_in  = S_HASH;
                     end
                  end
                  OP_LOOKUP: begin
                     mod_start = 1'b1;
                     state_in  = S_HASH;
                  end
                  OP_CLEAR: begin
                     nodes_used_in = '0;
                     clr_cnt_in    = '0;
                     clr_rsp_in    = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  default: begin
                     // Unused operation code: nothing changes.
                     status_in = ST_OK;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end
         S_HASH: begin
            if (mod_done) begin
               bkt_rd_en = 1'b1;
               state_in  = S_HEAD;
            end
         end
         S_HEAD: begin
            if (op_ff == OP_INSERT) begin
               node_wr_en    = 1'b1;
               bkt_wr_en     = 1'b1;
               bkt_wr_data   = {1'b1, new_idx};
               nodes_used_in = nodes_used_ff + 1'b1;
               status_in     = ST_OK;
               state_in      = S_RESP;
            end else if (!bkt_rd_data[NB]) begin
               status_in = ST_MISS;
               state_in  = S_RESP;
            end else begin
               node_rd_en = 1'b1;
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            if (node_key == key_ff) begin
               status_in = ST_OK;
               found_in  = node_handle;
               state_in  = S_RESP;
            end else if (!node_next[NB]) begin
               status_in = ST_MISS;
               state_in  = S_RESP;
            end else begin
               node_rd_en   = 1'b1;
               node_rd_addr = node_next[NB-1:0];
            end
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      handle_ff <= handle_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         clr_rsp_ff    <= 1'b0;
         nodes_used_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_rsp_ff    <= clr_rsp_in;
         nodes_used_ff <= nodes_used_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = RSP_DATA_W'(found_ff);
   assign rsp_tuser  = status_ff;

   `CHT_ASSERT_NOW(a_one_at_a_time, req_tready, !rsp_tvalid, "ready with response pending")
   `CHT_ASSERT_NOW(a_pool_bound, 1'b1, nodes_used_ff <= NU_W'(NODES), "node count past pool")
   `CHT_ASSERT_NOW(a_full_status, rsp_tvalid && status_ff == ST_FULL, pool_full, "pool not full")
   `CHT_ASSERT_NOW(a_done_in_hash, mod_done, state_ff == S_HASH, "index done outside hash")
   `CHT_ASSERT_NEXT(a_alloc, node_wr_en, nodes_used_ff == $past(nodes_used_ff) + 1'b1, "no alloc")

endmodule
